>>> hw/rtl/gimbal_target_pd_controller_macros.svh
// Assertion macros shared by the gimbal target PD controller RTL.
`ifndef GIMBAL_TARGET_PD_CONTROLLER_MACROS_SVH
`define GIMBAL_TARGET_PD_CONTROLLER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GTPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define GTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gtpd_pkg.sv
// Shared types, constants and helper functions of the gimbal target PD controller.
package gtpd_pkg;

  // CORDIC limits and angle constants.
  localparam int unsigned STEPS_MAX  = 24;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic [31:0] ATAN_Q30 [STEPS_MAX] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // Angle limits in Q3.13.
  localparam logic signed [18:0] YAW_LIM   = 19'sd25736;
  localparam logic signed [18:0] PITCH_LIM = 19'sd12868;

  // Index of the last square root iteration for a 60 bit radicand.
  localparam logic [4:0] SQRT_LAST = 5'd29;

  // Division by 1000 through a reciprocal: q = (n * DIV_RECIP) >>> 38.
  localparam logic signed [31:0] DIV_RECIP = 32'sd274877907;
  localparam logic signed [31:0] DIV_CONST = 32'sd1000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_YAW_SMOOTH   = 3'd0,
    CFG_PITCH_SMOOTH = 3'd1,
    CFG_TARGET_DIST  = 3'd2,
    CFG_DIST_KP      = 3'd3,
    CFG_DIST_KD      = 3'd4,
    CFG_YAW_KP       = 3'd5,
    CFG_YAW_KD       = 3'd6
  } cfg_idx_e;

  // Sequencer steps of the shared multiply-accumulate datapath.
  typedef enum logic [4:0] {
    STEP_SQ0     = 5'd0,
    STEP_SQ1     = 5'd1,
    STEP_SQ2     = 5'd2,
    STEP_SQ3     = 5'd3,
    STEP_PLP_A   = 5'd4,
    STEP_PLP_B   = 5'd5,
    STEP_YLP_A   = 5'd6,
    STEP_YLP_B   = 5'd7,
    STEP_DIV_MUL = 5'd8,
    STEP_DIV_Q   = 5'd9,
    STEP_DIV_FIX = 5'd10,
    STEP_SPD_P   = 5'd11,
    STEP_SPD_D   = 5'd12,
    STEP_TRN_P   = 5'd13,
    STEP_TRN_D   = 5'd14,
    STEP_TRN_ACC = 5'd15,
    STEP_FINISH  = 5'd16
  } step_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  step_en;
    step_e step;
    logic  start_yaw;
    logic  take_yaw;
    logic  start_pitch;
    logic  take_pitch;
    logic  commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic depth_zero;
    logic cordic_busy;
    logic sqrt_busy;
  } status_t;

  // Saturate a wide signed value to 24 bits.
  function automatic logic [23:0] sat24(input logic signed [63:0] v);
    logic [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/gimbal_target_pd_controller.sv
// Top level of the gimbal target PD controller: controller and datapath.
//
// Channel  Direction  Handshake                     Payload
// s_axis   in         s_axis_tvalid/s_axis_tready   cam_x_mm, cam_y_mm, cam_z_mm
// m_axis   out        m_axis_tvalid/m_axis_tready   speed_x, pitch_cmd, turn_rate
// cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// An item with nonzero depth runs the 30-step square root (with the yaw CORDIC
// beside it) and then the pitch CORDIC on the shared rotation unit; a zero-depth
// item skips both angle units.
// The input is taken only between items; the finished result waits in an output
// register, and a stalled output holds the next item at its final step.
// Reset is asynchronous and active low; it restores register defaults and zero state.
module gimbal_target_pd_controller #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // cam_x_mm[15:0], cam_y_mm[31:16], cam_z_mm[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // speed_x[23:0], pitch_cmd[37:24], turn_rate[61:38]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  gtpd_pkg::cmd_t    cmd;
  gtpd_pkg::status_t status;
  logic              cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  gtpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gtpd_datapath #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .cfg_valid_i(cfg_xfer),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule

>>> hw/rtl/gtpd_cordic.sv
// Iterative vectoring CORDIC giving atan2(y, x) in Q3.13 radians.
module gtpd_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] x_i,
  input  logic signed [33:0] y_i,
  output logic               busy_o,
  output logic signed [18:0] angle_o
);

  localparam int unsigned STEP_N = (CORDIC_STEPS < gtpd_pkg::STEPS_MAX) ?
                                   CORDIC_STEPS : gtpd_pkg::STEPS_MAX;
  localparam int unsigned CW = $clog2(STEP_N);
  localparam logic [CW-1:0] LAST = CW'(STEP_N - 1);

  logic               busy_q, busy_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [35:0] z_q, z_d;
  logic signed [33:0] dx, dy;
  logic signed [35:0] atan_v;
  logic signed [35:0] z_rnd;

  // One micro-rotation per cycle; operands are latched on start.
  always_comb begin
    dx     = x_q >>> cnt_q;
    dy     = y_q >>> cnt_q;
    atan_v = signed'({4'b0, gtpd_pkg::ATAN_Q30[gtpd_pkg::ATAN_IDX_W'(cnt_q)]});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      cnt_d = '0;
      if (x_i == '0 && y_i == '0) begin
        busy_d = 1'b0;
        z_d    = '0;
      end else if (x_i < 0) begin
        busy_d = 1'b1;
        x_d    = -x_i;
        y_d    = -y_i;
        z_d    = (y_i >= 0) ? gtpd_pkg::PI_Q30 : -gtpd_pkg::PI_Q30;
      end else begin
        busy_d = 1'b1;
        x_d    = x_i;
        y_d    = y_i;
        z_d    = '0;
      end
    end else if (busy_q) begin
      if (!y_q[33]) begin
        x_d = x_q + dy;
        y_d = y_q - dx;
        z_d = z_q + atan_v;
      end else begin
        x_d = x_q - dy;
        y_d = y_q + dx;
        z_d = z_q - atan_v;
      end
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  // Control state is reset; the rotation registers are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // Round the Q30 angle to Q3.13.
  assign z_rnd   = z_q + 36'sd65536;
  assign angle_o = z_rnd[35:17];
  assign busy_o  = busy_q;

endmodule

>>> hw/rtl/gtpd_isqrt.sv
// Iterative integer square root of a 60 bit radicand, two radicand bits per cycle.
module gtpd_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [59:0] rad_i,
  output logic        busy_o,
  output logic [30:0] root_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [59:0] v_q, v_d;
  logic [60:0] r_q, r_d;
  logic [59:0] b_q, b_d;
  logic [60:0] trial;

  // Restoring digit-by-digit root: one result bit per cycle.
  always_comb begin
    trial  = r_q + {1'b0, b_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      v_d    = rad_i;
      r_d    = '0;
      b_d    = 60'd1 << 58;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d = v_q - trial[59:0];
        r_d = (r_q >> 1) + {1'b0, b_q};
      end else begin
        r_d = r_q >> 1;
      end
      b_d = b_q >> 2;
      if (cnt_q == gtpd_pkg::SQRT_LAST) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign busy_o = busy_q;
  assign root_o = r_q[30:0];

endmodule

>>> hw/rtl/gtpd_datapath.sv
// Datapath: configuration registers, angle units, shared multiply-accumulate and state.
module gtpd_datapath #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtpd_pkg::cmd_t      cmd_i,
  output gtpd_pkg::status_t   status_o,
  input  logic [47:0]         in_data_i,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output logic [63:0]         out_data_o
);

  // Configuration registers.
  logic [15:0]        yaw_a_q, pitch_a_q;
  logic [14:0]        target_q;
  logic signed [15:0] dist_kp_q, dist_kd_q, yaw_kp_q, yaw_kd_q;

  // Per-item operands.
  logic signed [16:0] t0_q, t1_q;
  logic [15:0]        t2_mag_q;
  logic               zero_q;
  logic signed [15:0] yaw_raw_q, pitch_raw_q;

  // Controller state carried between items.
  logic signed [15:0] yaw_f_q, pitch_f_q;
  logic signed [23:0] last_de_q;
  logic signed [15:0] last_ye_q;

  // Multiply-accumulate and intermediate results.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d, prod_q, acc_q;
  logic signed [31:0] quo_q;
  logic signed [23:0] de_q;
  logic [23:0]        speed_q;

  // Output register.
  logic [23:0]        out_speed_q, out_turn_q;
  logic [13:0]        out_pitch_q;

  // Input decoding.
  logic signed [16:0] cx_ext, cy_ext, cz_ext, t2_val;
  logic signed [16:0] t0_new;
  logic               zero_new;

  // Unit connections.
  logic               cordic_start, cordic_busy, sqrt_busy;
  logic signed [33:0] cordic_x, cordic_y;
  logic signed [18:0] cordic_angle;
  logic [30:0]        sqrt_root;

  // Arithmetic helpers.
  logic signed [31:0] dist_n;
  logic signed [31:0] rem;
  logic signed [24:0] de_diff;
  logic signed [16:0] ye_diff;
  logic signed [15:0] yaw_clamped, pitch_clamped;
  logic signed [63:0] spd_shift, trn_shift;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_a_q   <= 16'd58982;
      pitch_a_q <= 16'd58982;
      target_q  <= 15'd1000;
      dist_kp_q <= '0;
      dist_kd_q <= '0;
      yaw_kp_q  <= '0;
      yaw_kd_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gtpd_pkg::CFG_YAW_SMOOTH:   yaw_a_q   <= cfg_data_i;
        gtpd_pkg::CFG_PITCH_SMOOTH: pitch_a_q <= cfg_data_i;
        gtpd_pkg::CFG_TARGET_DIST:  target_q  <= cfg_data_i[14:0];
        gtpd_pkg::CFG_DIST_KP:      dist_kp_q <= cfg_data_i;
        gtpd_pkg::CFG_DIST_KD:      dist_kd_q <= cfg_data_i;
        gtpd_pkg::CFG_YAW_KP:       yaw_kp_q  <= cfg_data_i;
        gtpd_pkg::CFG_YAW_KD:       yaw_kd_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Camera to gimbal frame: T = (z+100, -x, -y-260); without depth the first term is the target.
  assign cx_ext   = {in_data_i[15], in_data_i[15:0]};
  assign cy_ext   = {in_data_i[31], in_data_i[31:16]};
  assign cz_ext   = {in_data_i[47], in_data_i[47:32]};
  assign zero_new = (in_data_i[47:32] == 16'd0);
  assign t2_val   = -cy_ext - 17'sd260;
  assign t0_new   = zero_new ? signed'({2'b00, target_q}) : cz_ext + 17'sd100;

  // Angle units.
  assign cordic_start = cmd_i.start_yaw | cmd_i.start_pitch;
  assign cordic_x = cmd_i.start_pitch ? signed'({3'b000, sqrt_root})
                                      : 34'(t0_q) <<< 14;
  assign cordic_y = cmd_i.start_pitch ? signed'({4'b0000, t2_mag_q, 14'd0})
                                      : 34'(t1_q) <<< 14;

  gtpd_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .x_i    (cordic_x),
    .y_i    (cordic_y),
    .busy_o (cordic_busy),
    .angle_o(cordic_angle)
  );

  gtpd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start_yaw),
    .rad_i  ({acc_q[31:0], 28'd0}),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

  // Clamp the raw angles.
  always_comb begin
    if (cordic_angle > gtpd_pkg::YAW_LIM) begin
      yaw_clamped = gtpd_pkg::YAW_LIM[15:0];
    end else if (cordic_angle < -gtpd_pkg::YAW_LIM) begin
      yaw_clamped = 16'(-gtpd_pkg::YAW_LIM);
    end else begin
      yaw_clamped = cordic_angle[15:0];
    end
    if (cordic_angle > gtpd_pkg::PITCH_LIM) begin
      pitch_clamped = gtpd_pkg::PITCH_LIM[15:0];
    end else if (cordic_angle < 0) begin
      pitch_clamped = '0;
    end else begin
      pitch_clamped = cordic_angle[15:0];
    end
  end

  // Distance error numerator and PD differences.
  assign dist_n  = ((32'(t0_q) - 32'(signed'({2'b00, target_q}))) <<< 12) + 32'sd500;
  assign rem     = dist_n - ((quo_q <<< 10) - (quo_q <<< 4) - (quo_q <<< 3));
  assign de_diff = 25'(de_q) - 25'(last_de_q);
  assign ye_diff = 17'(yaw_f_q) - 17'(last_ye_q);

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      gtpd_pkg::STEP_SQ0: begin
        mul_a = 32'(t0_q);
        mul_b = 32'(t0_q);
      end
      gtpd_pkg::STEP_SQ1: begin
        mul_a = 32'(t1_q);
        mul_b = 32'(t1_q);
      end
      gtpd_pkg::STEP_PLP_A: begin
        mul_a = signed'({16'd0, pitch_a_q});
        mul_b = 32'(pitch_f_q);
      end
      gtpd_pkg::STEP_PLP_B: begin
        mul_a = signed'({15'd0, 17'h10000 - {1'b0, pitch_a_q}});
        mul_b = 32'(pitch_raw_q);
      end
      gtpd_pkg::STEP_YLP_A: begin
        mul_a = signed'({16'd0, yaw_a_q});
        mul_b = 32'(yaw_f_q);
      end
      gtpd_pkg::STEP_YLP_B: begin
        mul_a = signed'({15'd0, 17'h10000 - {1'b0, yaw_a_q}});
        mul_b = 32'(yaw_raw_q);
      end
      gtpd_pkg::STEP_DIV_MUL: begin
        mul_a = dist_n;
        mul_b = gtpd_pkg::DIV_RECIP;
      end
      gtpd_pkg::STEP_SPD_P: begin
        mul_a = 32'(dist_kp_q);
        mul_b = 32'(de_q);
      end
      gtpd_pkg::STEP_SPD_D: begin
        mul_a = 32'(dist_kd_q);
        mul_b = 32'(de_diff);
      end
      gtpd_pkg::STEP_TRN_P: begin
        mul_a = 32'(yaw_kp_q);
        mul_b = 32'(yaw_f_q);
      end
      gtpd_pkg::STEP_TRN_D: begin
        mul_a = 32'(yaw_kd_q);
        mul_b = 32'(ye_diff);
      end
      default: ;
    endcase
  end

  assign prod_d    = mul_a * mul_b;
  assign spd_shift = acc_q >>> 8;
  assign trn_shift = acc_q >>> 9;

  // Product register.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Operand capture and accumulator sequencing.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t0_q        <= t0_new;
      t1_q        <= -cx_ext;
      t2_mag_q    <= t2_val[16] ? 16'(-t2_val) : t2_val[15:0];
      zero_q      <= zero_new;
      yaw_raw_q   <= '0;
      pitch_raw_q <= '0;
    end
    if (cmd_i.take_yaw) begin
      yaw_raw_q <= yaw_clamped;
    end
    if (cmd_i.take_pitch) begin
      pitch_raw_q <= pitch_clamped;
    end
    if (cmd_i.step_en) begin
      case (cmd_i.step)
        gtpd_pkg::STEP_SQ1:     acc_q <= prod_q;
        gtpd_pkg::STEP_SQ2:     acc_q <= acc_q + prod_q;
        gtpd_pkg::STEP_PLP_B:   acc_q <= prod_q + 64'sd32768;
        gtpd_pkg::STEP_YLP_A:   acc_q <= acc_q + prod_q;
        gtpd_pkg::STEP_YLP_B:   acc_q <= prod_q + 64'sd32768;
        gtpd_pkg::STEP_DIV_MUL: acc_q <= acc_q + prod_q;
        gtpd_pkg::STEP_DIV_Q:   quo_q <= 32'(prod_q >>> 38);
        gtpd_pkg::STEP_DIV_FIX: begin
          if (rem < 0) begin
            de_q <= 24'(quo_q - 32'sd1);
          end else if (rem >= gtpd_pkg::DIV_CONST) begin
            de_q <= 24'(quo_q + 32'sd1);
          end else begin
            de_q <= 24'(quo_q);
          end
        end
        gtpd_pkg::STEP_SPD_D:   acc_q <= prod_q + 64'sd128;
        gtpd_pkg::STEP_TRN_P:   acc_q <= acc_q + prod_q;
        gtpd_pkg::STEP_TRN_D: begin
          speed_q <= gtpd_pkg::sat24(spd_shift);
          acc_q   <= prod_q + 64'sd256;
        end
        gtpd_pkg::STEP_TRN_ACC: acc_q <= acc_q + prod_q;
        default: ;
      endcase
    end
  end

  // Filter and PD state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_f_q <= '0;
      yaw_f_q   <= '0;
      last_de_q <= '0;
      last_ye_q <= '0;
    end else if (cmd_i.step_en) begin
      if (cmd_i.step == gtpd_pkg::STEP_YLP_B) begin
        pitch_f_q <= acc_q[31:16];
      end
      if (cmd_i.step == gtpd_pkg::STEP_DIV_Q) begin
        yaw_f_q <= acc_q[31:16];
      end
      if (cmd_i.commit) begin
        last_de_q <= de_q;
        last_ye_q <= yaw_f_q;
      end
    end
  end

  // Result register, loaded on commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_speed_q <= speed_q;
      out_pitch_q <= pitch_f_q[13:0];
      out_turn_q  <= gtpd_pkg::sat24(trn_shift);
    end
  end

  assign out_data_o = {2'b00, out_turn_q, out_pitch_q, out_speed_q};

  assign status_o.depth_zero  = zero_q;
  assign status_o.cordic_busy = cordic_busy;
  assign status_o.sqrt_busy   = sqrt_busy;

endmodule

>>> hw/rtl/gtpd_ctrl.sv
// Controller state machine: input and output handshakes and step sequencing.
`include "gimbal_target_pd_controller_macros.svh"

module gtpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gtpd_pkg::status_t status_i,
  output gtpd_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_YAW   = 5'b00100,
    S_PITCH = 5'b01000,
    S_POST  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  gtpd_pkg::step_e step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic            in_xfer;
  logic            slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
          step_d     = gtpd_pkg::STEP_SQ0;
        end
      end
      S_PREP: begin
        cmd_o.step_en = 1'b1;
        if (step_q == gtpd_pkg::STEP_SQ0 && status_i.depth_zero) begin
          state_d = S_POST;
          step_d  = gtpd_pkg::STEP_PLP_A;
        end else if (step_q == gtpd_pkg::STEP_SQ3) begin
          cmd_o.start_yaw = 1'b1;
          state_d         = S_YAW;
        end else begin
          step_d = gtpd_pkg::step_e'(step_q + 5'd1);
        end
      end
      S_YAW: begin
        if (!status_i.cordic_busy && !status_i.sqrt_busy) begin
          cmd_o.take_yaw    = 1'b1;
          cmd_o.start_pitch = 1'b1;
          state_d           = S_PITCH;
        end
      end
      S_PITCH: begin
        if (!status_i.cordic_busy) begin
          cmd_o.take_pitch = 1'b1;
          state_d          = S_POST;
          step_d           = gtpd_pkg::STEP_PLP_A;
        end
      end
      S_POST: begin
        if (step_q == gtpd_pkg::STEP_FINISH) begin
          if (slot_free) begin
            cmd_o.step_en = 1'b1;
            cmd_o.commit  = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.step_en = 1'b1;
          step_d        = gtpd_pkg::step_e'(step_q + 5'd1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid flag: set on commit, cleared by an output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= gtpd_pkg::STEP_SQ0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `GTPD_ASSERT(a_commit_slot, cmd_o.commit |-> (!out_valid_q || out_ready_i), "commit overwrote a pending result")
  `GTPD_ASSERT(a_valid_rise, $rose(out_valid_q) |-> $past(cmd_o.commit), "result valid without commit")
  `GTPD_ASSERT_NEXT(a_accept_busy, in_xfer, state_q == S_PREP, "accepted item did not start work")
  `GTPD_ASSERT_NEXT(a_pitch_start, cmd_o.start_pitch, state_q == S_PITCH, "pitch angle not awaited")

endmodule
